FILE: rtl/modinv_pkg.sv
// Shared types and constants of the modular inverse block.
// No dependencies; used by every module under rtl.
`default_nettype none
package modinv_pkg;
	localparam int PRIME_W   = 31;  // width of each prime input
	localparam int EXP_W     = 62;  // width of the exponent input
	localparam int OUT_W     = 62;  // width of the inverse output
	localparam int MOD_W_DEF = 62;  // default modulus width
	localparam int COEF_W    = 64;  // Bezout coefficient and dividend width
	localparam int CNT_W     = $clog2(COEF_W);

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;          // capture the input beat
		logic mul;           // form phi and seed the Euclid registers
		logic div_init_euc;  // start dividing hi by lo
		logic div_init_red;  // start reducing the coefficient modulo phi
		logic div_step;      // one quotient bit
		logic euc_upd;       // rotate remainders and coefficients
		logic out_load;      // load the result register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic lo_zero;
		logic fail;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/modinv_dp.sv
// Datapath: phi multiplier, shared bit-serial divider, Bezout coefficients.
// Depends on modinv_pkg; driven by modinv_ctrl through cmd_t.
`default_nettype none
module modinv_dp import modinv_pkg::*; #(
	parameter int MOD_WIDTH = MOD_W_DEF
) (
	input  wire logic               clk,
	input  wire logic [PRIME_W-1:0] prime_p,
	input  wire logic [PRIME_W-1:0] prime_q,
	input  wire logic [EXP_W-1:0]   exponent,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic [OUT_W-1:0]        inverse,
	output logic                    no_inverse
);
	localparam int W = MOD_WIDTH;

	logic [PRIME_W-1:0]   pm1_q, qm1_q;
	logic [W-1:0]         e_q, phi_q, hi_q, lo_q, rem_q, sor_q;
	logic                 ezero_q, neg_q;
	logic [COEF_W-1:0]    t0_q, t1_q, m_q, dvd_q;
	logic [2*PRIME_W-1:0] prod;
	logic [W:0]           trial, diff;
	logic                 ge;
	logic [W-1:0]         red_val;

	assign prod  = pm1_q * qm1_q;
	assign trial = {rem_q, dvd_q[COEF_W-1]};
	assign diff  = trial - {1'b0, sor_q};
	assign ge    = trial >= {1'b0, sor_q};

	assign sts.lo_zero = (lo_q == '0);
	assign sts.fail    = (phi_q == '0) || ezero_q || (hi_q != W'(1));

	// fold a negative coefficient back into 0..phi-1
	assign red_val = !neg_q ? rem_q : ((rem_q == '0) ? '0 : phi_q - rem_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pm1_q   <= (prime_p == '0) ? '0 : prime_p - PRIME_W'(1);
			qm1_q   <= (prime_q == '0) ? '0 : prime_q - PRIME_W'(1);
			e_q     <= exponent[W-1:0];
			ezero_q <= (exponent[W-1:0] == '0);
		end
		if (cmd.mul) begin
			phi_q <= prod[W-1:0];
			hi_q  <= prod[W-1:0];
			lo_q  <= e_q;
			t0_q  <= '0;
			t1_q  <= COEF_W'(1);
		end
		if (cmd.div_init_euc) begin
			dvd_q <= COEF_W'(hi_q);
			sor_q <= lo_q;
			rem_q <= '0;
			m_q   <= '0;
		end
		if (cmd.div_init_red) begin
			dvd_q <= t0_q[COEF_W-1] ? '0 - t0_q : t0_q;
			neg_q <= t0_q[COEF_W-1];
			sor_q <= phi_q;
			rem_q <= '0;
			m_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			dvd_q <= dvd_q << 1;
			// accumulate quotient * t1 one quotient bit at a time
			m_q   <= (m_q << 1) + (ge ? t1_q : '0);
		end
		if (cmd.euc_upd) begin
			hi_q <= lo_q;
			lo_q <= rem_q;
			t0_q <= t1_q;
			t1_q <= t0_q - m_q;
		end
		if (cmd.out_load) begin
			inverse    <= sts.fail ? '0 : OUT_W'(red_val);
			no_inverse <= sts.fail;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/modinv_ctrl.sv
// Controller: sequences setup, Euclid steps, final reduction and output.
// Depends on modinv_pkg; commands modinv_dp through cmd_t.
`default_nettype none
module modinv_ctrl import modinv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DIVE  = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_DIVR  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COEF_W - 1);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.lo_zero) state_d = S_FIN;
				else begin
					cmd.div_init_euc = 1'b1;
					state_d = S_DIVE;
				end
			end
			S_DIVE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.euc_upd = 1'b1;
				state_d = S_CHECK;
			end
			S_FIN: begin
				if (sts.fail) state_d = S_OUT;
				else begin
					cmd.div_init_red = 1'b1;
					state_d = S_DIVR;
				end
			end
			S_DIVR: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the previous result has left
				cmd.out_load = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cmd.div_step ? cnt_q + CNT_W'(1) : '0;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: controller plus datapath.
// Depends on modinv_pkg, modinv_ctrl and modinv_dp.
//
// Computes d = e^-1 mod phi with phi = (p-1)(q-1), by the extended Euclidean
// algorithm, for RSA key setup. p and q below two count as one, so phi is 0.
// no_inverse is set, and inverse reads 0, when phi or e is zero or when
// gcd(e, phi) is not 1. One beat is taken at a time; in_ready is high only
// while the block is idle, and a finished result waits in an output register
// so the next beat can be accepted while it is pending. A run has setup (load
// and multiply), then a series of Euclid steps, each a check, a division by
// one shared restoring divider that makes one quotient bit a cycle over a
// 64-bit dividend, and an update; then one more check that finds the lower
// remainder zero, the final reduction modulo phi (skipped when no inverse
// exists), and the load of the output, which waits while an earlier result
// is still pending. A Euclid run takes at most about 1.44*MOD_WIDTH+2 steps,
// and typical keys need far fewer. The quotient times the coefficient is
// built alongside the division bit by bit, so there is no wide multiplier
// beyond the single 31x31 product that forms phi.
`default_nettype none
module modular_inverse_ext_euclid import modinv_pkg::*; #(
	parameter int MOD_WIDTH = MOD_W_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PRIME_W-1:0] prime_p,
	input  wire logic [PRIME_W-1:0] prime_q,
	input  wire logic [EXP_W-1:0]   exponent,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [OUT_W-1:0]        inverse,
	output logic                    no_inverse
);
	cmd_t cmd;
	sts_t sts;

	modinv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	modinv_dp #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
		.clk        (clk),
		.prime_p    (prime_p),
		.prime_q    (prime_q),
		.exponent   (exponent),
		.cmd        (cmd),
		.sts        (sts),
		.inverse    (inverse),
		.no_inverse (no_inverse)
	);

	// a failed inversion always reports zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_inverse |-> inverse == '0)
		else $error("inverse not zero on failure");

	// an accepted beat makes the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

	// a pending result is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");
endmodule
`default_nettype wire
